// ----- hdl/mcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Music command stream decoder package
// Shared types and constants for the decoder core and its result stage.
// ----------------------------------------------------------------------------
package mcsd_pkg;

	localparam int ByteW   = 8;
	localparam int KindW   = 3;
	localparam int CountW  = 6;
	localparam int CfgAddrW = 2;
	localparam int DataW   = 24;

	// Command byte boundaries.
	localparam logic [ByteW-1:0] CmdExt      = 8'h40;
	localparam logic [ByteW-1:0] CmdEnd      = 8'h80;
	localparam logic [ByteW-1:0] CountMask   = 8'h3F;
	localparam logic [ByteW-1:0] ChanMask    = 8'hC0;
	localparam logic [ByteW-1:0] DelayMask   = 8'h7F;

	// Configuration register indexes.
	localparam logic [CfgAddrW-1:0] RegLoopEnable     = 2'd0;
	localparam logic [CfgAddrW-1:0] RegTablePresent   = 2'd1;
	localparam logic [CfgAddrW-1:0] RegLastInstrument = 2'd2;

	// Extension channel 0 commands.
	localparam logic [ByteW-1:0] ExtAudioCtrl = 8'd0;
	localparam logic [ByteW-1:0] ExtAudioRate = 8'd1;
	localparam logic [ByteW-1:0] ExtTrigger   = 8'd2;

	typedef enum logic [2:0] {
		PH_CMD      = 3'd0,
		PH_PSG_VAL  = 3'd1,
		PH_EXT_HDR  = 3'd2,
		PH_PCM_CMD  = 3'd3,
		PH_PCM_ARG  = 3'd4,
		PH_EXT_SKIP = 3'd5,
		PH_YM_REG   = 3'd6,
		PH_YM_VAL   = 3'd7
	} phase_t;

	typedef enum logic [KindW-1:0] {
		KIND_PSG     = 3'd0,
		KIND_YM      = 3'd1,
		KIND_ACTRL   = 3'd2,
		KIND_ARATE   = 3'd3,
		KIND_TRIGGER = 3'd4,
		KIND_DELAY   = 3'd5,
		KIND_LOOP    = 3'd6,
		KIND_STOP    = 3'd7
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [ByteW-1:0]  target_reg;
		logic [ByteW-1:0]  data_value;
		logic [ByteW-1:0]  sample_rate;
	} result_t;

endpackage

// ----- hdl/mcsd_decode.sv -----
// ----------------------------------------------------------------------------
// Decoder core
// Holds the configuration and parse state, and decodes one stream byte per
// accepted word into at most one sound-chip action.
// ----------------------------------------------------------------------------
module mcsd_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [mcsd_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [mcsd_pkg::ByteW-1:0]    cfg_wdata,
	input  logic                          accept,
	input  logic [mcsd_pkg::ByteW-1:0]    stream_byte,
	output mcsd_pkg::result_t             res
);
	import mcsd_pkg::*;

	logic              loop_enable_q;
	logic              table_present_q;
	logic [ByteW-1:0]  last_instrument_q;

	phase_t            phase_q, phase_d;
	logic [CountW-1:0] remaining_q, remaining_d, rem_dec;
	logic [ByteW-1:0]  held_q, held_d;
	logic [ByteW-1:0]  rate_q, rate_d;
	logic              halted_q, halted_d;
	result_t           res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_enable_q     <= 1'b0;
			table_present_q   <= 1'b0;
			last_instrument_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				RegLoopEnable:     loop_enable_q     <= cfg_wdata[0];
				RegTablePresent:   table_present_q   <= cfg_wdata[0];
				RegLastInstrument: last_instrument_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign rem_dec = remaining_q - CountW'(1);

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		held_d      = held_q;
		rate_d      = rate_q;
		halted_d    = halted_q;
		res_d       = '0;
		res_d.kind  = KIND_PSG;
		if (!halted_q) begin
			case (phase_q)
				PH_CMD: begin
					if (stream_byte < CmdExt) begin
						held_d  = stream_byte;
						phase_d = PH_PSG_VAL;
					end else if (stream_byte == CmdExt) begin
						phase_d = PH_EXT_HDR;
					end else if (stream_byte < CmdEnd) begin
						remaining_d = stream_byte[CountW-1:0];
						phase_d     = PH_YM_REG;
					end else if (stream_byte == CmdEnd) begin
						res_d.valid = 1'b1;
						if (loop_enable_q) begin
							res_d.kind = KIND_LOOP;
						end else begin
							res_d.kind = KIND_STOP;
							halted_d   = 1'b1;
						end
					end else begin
						res_d.valid      = 1'b1;
						res_d.kind       = KIND_DELAY;
						res_d.data_value = stream_byte & DelayMask;
					end
				end
				PH_PSG_VAL: begin
					phase_d          = PH_CMD;
					res_d.valid      = 1'b1;
					res_d.kind       = KIND_PSG;
					res_d.target_reg = held_q;
					res_d.data_value = stream_byte;
				end
				PH_EXT_HDR: begin
					remaining_d = stream_byte[CountW-1:0];
					if ((stream_byte & CountMask) == '0) begin
						phase_d = PH_CMD;
					end else if ((stream_byte & ChanMask) == '0) begin
						phase_d = PH_PCM_CMD;
					end else begin
						phase_d = PH_EXT_SKIP;
					end
				end
				PH_PCM_CMD: begin
					held_d      = stream_byte;
					remaining_d = rem_dec;
					phase_d     = (rem_dec == '0) ? PH_CMD : PH_PCM_ARG;
				end
				PH_PCM_ARG: begin
					remaining_d      = rem_dec;
					phase_d          = (rem_dec == '0) ? PH_CMD : PH_PCM_CMD;
					res_d.data_value = stream_byte;
					if (held_q == ExtAudioCtrl) begin
						res_d.valid = 1'b1;
						res_d.kind  = KIND_ACTRL;
					end else if (held_q == ExtAudioRate) begin
						rate_d      = stream_byte;
						res_d.valid = 1'b1;
						res_d.kind  = KIND_ARATE;
					end else if (held_q == ExtTrigger && table_present_q &&
						stream_byte <= last_instrument_q) begin
						res_d.valid       = 1'b1;
						res_d.kind        = KIND_TRIGGER;
						res_d.sample_rate = rate_q;
					end
				end
				PH_EXT_SKIP: begin
					remaining_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = PH_CMD;
					end
				end
				PH_YM_REG: begin
					held_d  = stream_byte;
					phase_d = PH_YM_VAL;
				end
				PH_YM_VAL: begin
					remaining_d      = rem_dec;
					phase_d          = (rem_dec == '0) ? PH_CMD : PH_YM_REG;
					res_d.valid      = 1'b1;
					res_d.kind       = KIND_YM;
					res_d.target_reg = held_q;
					res_d.data_value = stream_byte;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CMD;
			remaining_q <= '0;
			held_q      <= '0;
			rate_q      <= '0;
			halted_q    <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			held_q      <= held_d;
			rate_q      <= rate_d;
			halted_q    <= halted_d;
		end
	end

	always_comb begin
		res       = res_d;
		res.valid = res_d.valid & accept;
	end

	// Once stopped, the decoder stays stopped until reset.
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |=> halted_q)
		else $error("halted flag cleared without reset");

	// Phases that count down block bytes are never entered with an empty count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PCM_CMD || phase_q == PH_PCM_ARG || phase_q == PH_EXT_SKIP ||
		 phase_q == PH_YM_REG || phase_q == PH_YM_VAL) |-> remaining_q != '0)
		else $error("counting phase with zero remaining");

	// A trigger only leaves when the table exists and the index is in range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_TRIGGER) |->
		(table_present_q && res.data_value <= last_instrument_q))
		else $error("trigger emitted without a valid table entry");

	// No action is produced after a stop.
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |-> !res.valid)
		else $error("result produced while halted");

endmodule

// ----- hdl/mcsd_out_buf.sv -----
// ----------------------------------------------------------------------------
// Result stage
// Output register with a skid register behind it, so the decoder can take a
// new word in the cycle that the downstream side stalls.
// ----------------------------------------------------------------------------
module mcsd_out_buf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcsd_pkg::result_t             res,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mcsd_pkg::result_t             out_res
);
	import mcsd_pkg::*;

	logic    main_v_q, skid_v_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop      = main_v_q & out_ready;
	assign in_ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (!main_v_q || pop) begin
			main_v_q <= res.valid;
		end else if (res.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (!main_v_q || pop) begin
			main_q <= res;
		end else if (res.valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = main_v_q;
	assign out_res   = main_q;

	// The skid register only fills behind a full output register.
	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> main_v_q)
		else $error("skid register holds a word while output register is empty");

	// A result arriving against a stalled output register is parked, not lost.
	assert property (@(posedge clk) disable iff (!arst_n)
		(main_v_q && !out_ready && !skid_v_q && res.valid) |=> skid_v_q)
		else $error("result dropped against stalled output");

	// A draining skid register hands its word to the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && pop) |=> (main_v_q && !skid_v_q))
		else $error("skid word not moved to output register");

endmodule

// ----- hdl/music_command_stream_decoder_top.sv -----
// Output: a result word appears on the master side in the cycle after the byte
// that causes it is accepted when the output register is free or being taken,
// and it stays there until it is taken.
// Throughput: one stream byte per cycle while results are taken. While the output
// word is stalled, bytes keep flowing until a second result word is parked in the
// skid register; s_tready then stays low until the output word is taken.
// Reset: arst_n clears the parse state, the kept rate and the configuration
// registers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Music command stream decoder, top level
// Decodes a byte stream of sound-chip commands into register writes,
// extension actions, delays and end-of-stream events.
// ----------------------------------------------------------------------------
module music_command_stream_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [mcsd_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [mcsd_pkg::ByteW-1:0]    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mcsd_pkg::ByteW-1:0]    s_tdata,  // [7:0] stream_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mcsd_pkg::DataW-1:0]    m_tdata,  // [7:0] target_reg, [15:8] data_value,
	                                                // [23:16] sample_rate
	output logic [mcsd_pkg::KindW-1:0]    m_tuser   // [2:0] kind
);
	import mcsd_pkg::*;

	logic    accept;
	result_t res;
	result_t out_res;

	assign accept = s_tvalid & s_tready;

	mcsd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.stream_byte (s_tdata),
		.res         (res)
	);

	mcsd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.sample_rate, out_res.data_value, out_res.target_reg};
	assign m_tuser = out_res.kind;

endmodule
